### src/spfe_pkg.sv
package spfe_pkg;

	// register map of the configuration port
	typedef enum logic [1:0] {
		CFG_BAND_LOW    = 2'd0,
		CFG_BAND_HIGH   = 2'd1,
		CFG_SAMPLE_RATE = 2'd2
	} spfe_cfg_idx_t;

	localparam logic [7:0]  BAND_LOW_RST    = 8'd9;
	localparam logic [7:0]  BAND_HIGH_RST   = 8'd51;
	localparam logic [15:0] SAMPLE_RATE_RST = 16'd4000;

	localparam int FFT_POINTS_DEF = 512;

	// iterative divider operand widths
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 35;

	// peak queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// largest magnitude of the Q8 offset
	localparam logic [7:0] OFF_LIMIT = 8'd128;

	typedef struct packed {
		logic [7:0]  band_low;
		logic [7:0]  band_high;
		logic [15:0] sample_rate;
	} spfe_cfg_t;

	// frame summary handed from front to back
	typedef struct packed {
		logic [7:0]  best_bin;
		logic [31:0] left;
		logic [31:0] center;
		logic [31:0] right;
		logic        refine_ok;
	} spfe_peak_t;

	typedef struct packed {
		logic busy;
		logic done;
	} spfe_div_stat_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_PREP,
		BK_CHK,
		BK_DIV_OFF,
		BK_POS,
		BK_MUL,
		BK_FRQ,
		BK_DONE
	} spfe_bk_state_t;

endpackage

### src/spfe_front.sv
module spfe_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spfe_pkg::spfe_cfg_t    cfg,
	input  logic                   bin_valid,
	output logic                   bin_stall,
	input  logic [31:0]            bin_power,
	input  logic                   frame_end,
	output logic                   q_push,
	output spfe_pkg::spfe_peak_t   q_data,
	input  logic                   q_full
);
	import spfe_pkg::*;

	logic [7:0]  bin_cnt_q;
	logic        past_last_q;
	logic [31:0] prev_pwr_q;
	logic [31:0] best_pwr_q;
	logic [7:0]  best_bin_q;
	logic [31:0] left_q;
	logic [31:0] right_q;
	logic        await_q;

	logic        accept;
	logic        frame_start;
	logic [7:0]  high;
	logic        in_band;
	logic        take;
	logic [31:0] base_prev, base_best_pwr, base_left, base_right;
	logic [7:0]  base_best_bin;
	logic        base_await;
	logic [31:0] nxt_best_pwr, nxt_left, nxt_right;
	logic [7:0]  nxt_best_bin;
	logic        nxt_await;
	logic [31:0] eff_best_pwr, eff_left, eff_right;
	logic [7:0]  eff_best_bin;
	logic        eff_await;

	// only the last bin waits for room in the queue
	assign bin_stall = frame_end & q_full;
	assign accept    = bin_valid & ~bin_stall;
	assign q_push    = accept & frame_end;

	// search step for the current bin
	always_comb begin
		high        = (cfg.band_high < cfg.band_low) ? cfg.band_low : cfg.band_high;
		frame_start = (bin_cnt_q == 8'd0);

		base_prev     = frame_start ? 32'd0 : prev_pwr_q;
		base_best_pwr = frame_start ? 32'd0 : best_pwr_q;
		base_best_bin = frame_start ? cfg.band_low : best_bin_q;
		base_left     = frame_start ? 32'd0 : left_q;
		base_right    = frame_start ? 32'd0 : right_q;
		base_await    = frame_start ? 1'b0 : await_q;

		in_band = (bin_cnt_q >= cfg.band_low) && (bin_cnt_q <= high);
		take    = in_band && ((bin_cnt_q == cfg.band_low) || (bin_power > base_best_pwr));

		nxt_best_pwr = base_best_pwr;
		nxt_best_bin = base_best_bin;
		nxt_left     = base_left;
		nxt_right    = base_right;
		nxt_await    = base_await;
		if (take) begin
			nxt_best_pwr = bin_power;
			nxt_best_bin = bin_cnt_q;
			nxt_left     = base_prev;
			nxt_await    = 1'b1;
		end else if (base_await) begin
			nxt_right = bin_power;
			nxt_await = 1'b0;
		end

		// bins past the counter range leave the search untouched
		eff_best_pwr = past_last_q ? best_pwr_q : nxt_best_pwr;
		eff_best_bin = past_last_q ? best_bin_q : nxt_best_bin;
		eff_left     = past_last_q ? left_q     : nxt_left;
		eff_right    = past_last_q ? right_q    : nxt_right;
		eff_await    = past_last_q ? await_q    : nxt_await;

		q_data.best_bin  = eff_best_bin;
		q_data.left      = eff_left;
		q_data.center    = eff_best_pwr;
		q_data.right     = eff_right;
		q_data.refine_ok = (eff_best_bin > cfg.band_low) && (eff_best_bin < high) && !eff_await;
	end

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pwr_q <= '0;
			best_pwr_q <= '0;
			best_bin_q <= '0;
			left_q     <= '0;
			right_q    <= '0;
			await_q    <= 1'b0;
		end else if (accept && !past_last_q) begin
			prev_pwr_q <= bin_power;
			best_pwr_q <= nxt_best_pwr;
			best_bin_q <= nxt_best_bin;
			left_q     <= nxt_left;
			right_q    <= nxt_right;
			await_q    <= nxt_await;
		end
	end

	// bin position within the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q   <= '0;
			past_last_q <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				bin_cnt_q   <= '0;
				past_last_q <= 1'b0;
			end else if (bin_cnt_q == 8'd255) begin
				past_last_q <= 1'b1;
			end else if (!past_last_q) begin
				bin_cnt_q <= bin_cnt_q + 8'd1;
			end
		end
	end

endmodule

### src/spfe_queue.sv
module spfe_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  spfe_pkg::spfe_peak_t   push_data,
	output logic                   full,
	input  logic                   pop,
	output spfe_pkg::spfe_peak_t   pop_data,
	output logic                   nempty
);
	import spfe_pkg::*;

	spfe_peak_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign nempty   = (cnt_q != '0);
	assign pop_data = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### src/spfe_div.sv
module spfe_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [spfe_pkg::DIV_NUM_W-1:0]    num,
	input  logic [spfe_pkg::DIV_DEN_W-1:0]    den,
	output spfe_pkg::spfe_div_stat_t          stat,
	output logic [spfe_pkg::DIV_NUM_W-1:0]    quo
);
	import spfe_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

	// one restoring step: bring down the next numerator bit
	always_comb begin
		shifted = {rem_q, quo_q[DIV_NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIV_NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### src/spfe_back.sv
module spfe_back #(
	parameter int FFT_POINTS = spfe_pkg::FFT_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [15:0]                       sample_rate,
	input  logic                              q_nempty,
	input  spfe_pkg::spfe_peak_t              q_data,
	output logic                              q_pop,
	output logic                              div_start,
	output logic [spfe_pkg::DIV_NUM_W-1:0]    div_num,
	output logic [spfe_pkg::DIV_DEN_W-1:0]    div_den,
	input  spfe_pkg::spfe_div_stat_t          div_stat,
	input  logic [spfe_pkg::DIV_NUM_W-1:0]    div_quo,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [15:0]                       frequency_hz,
	output logic [7:0]                        peak_index,
	output logic signed [8:0]                 fraction_q8
);
	import spfe_pkg::*;

	// FFT_POINTS is a power of two, so the scale by FFT_POINTS*256 is a shift
	localparam int FRQ_SH = $clog2(FFT_POINTS) + 8;

	spfe_bk_state_t              state_q, state_nxt;
	spfe_peak_t                  ent_q;
	logic signed [DIV_NUM_W-1:0] num_q;
	logic signed [DIV_DEN_W-1:0] den_q;
	logic                        neg_q;
	logic signed [8:0]           off_q;
	logic [16:0]                 pos_q;
	logic [32:0]                 prod_q;
	logic [15:0]                 frq_q;

	logic                        res_valid_q;
	logic [15:0]                 res_frq_q;
	logic [7:0]                  res_bin_q;
	logic signed [8:0]           res_frac_q;

	logic                        go_div;
	logic                        out_free;
	logic                        out_load;
	logic [DIV_NUM_W-1:0]        num_mag;
	logic [DIV_DEN_W-1:0]        den_mag;
	logic signed [32:0]          lr_diff;
	logic [7:0]                  quo_clip;
	logic signed [17:0]          pos_sum;

	assign res_valid    = res_valid_q;
	assign frequency_hz = res_frq_q;
	assign peak_index   = res_bin_q;
	assign fraction_q8  = res_frac_q;

	assign out_free = !res_valid_q || !res_stall;
	assign go_div   = ent_q.refine_ok && (den_q != '0);

	// operand and result shaping
	always_comb begin
		lr_diff  = $signed({1'b0, ent_q.left}) - $signed({1'b0, ent_q.right});
		num_mag  = num_q[DIV_NUM_W-1] ? DIV_NUM_W'(-num_q) : DIV_NUM_W'(num_q);
		den_mag  = den_q[DIV_DEN_W-1] ? DIV_DEN_W'(-den_q) : DIV_DEN_W'(den_q);
		quo_clip = (div_quo > DIV_NUM_W'(OFF_LIMIT)) ? OFF_LIMIT : div_quo[7:0];
		pos_sum  = $signed({2'b00, ent_q.best_bin, 8'd0}) + 18'(off_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE:    if (q_nempty) state_nxt = BK_PREP;
			BK_PREP:    state_nxt = BK_CHK;
			BK_CHK:     state_nxt = go_div ? BK_DIV_OFF : BK_POS;
			BK_DIV_OFF: if (div_stat.done) state_nxt = BK_POS;
			BK_POS:     state_nxt = BK_MUL;
			BK_MUL:     state_nxt = BK_FRQ;
			BK_FRQ:     state_nxt = BK_DONE;
			BK_DONE:    if (out_free) state_nxt = BK_IDLE;
			default:    state_nxt = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		div_num   = num_mag;
		div_den   = den_mag;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: q_pop = q_nempty;
			BK_CHK:  div_start = go_div;
			BK_DONE: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_data;
		end
		if (state_q == BK_PREP) begin
			num_q <= {lr_diff, 7'd0};
			den_q <= $signed({3'b000, ent_q.left}) - $signed({2'b00, ent_q.center, 1'b0})
				+ $signed({3'b000, ent_q.right});
		end
		if (state_q == BK_CHK) begin
			neg_q <= num_q[DIV_NUM_W-1] ^ den_q[DIV_DEN_W-1];
			if (!go_div) begin
				off_q <= '0;
			end
		end
		if (state_q == BK_DIV_OFF && div_stat.done) begin
			off_q <= neg_q ? -$signed({1'b0, quo_clip}) : $signed({1'b0, quo_clip});
		end
		if (state_q == BK_POS) begin
			pos_q <= pos_sum[17] ? 17'd0 : pos_sum[16:0];
		end
		if (state_q == BK_MUL) begin
			prod_q <= pos_q * sample_rate;
		end
		if (state_q == BK_FRQ) begin
			frq_q <= 16'(prod_q >> FRQ_SH);
		end
		if (out_load) begin
			res_frq_q  <= frq_q;
			res_bin_q  <= ent_q.best_bin;
			res_frac_q <= off_q;
		end
	end

	// output register holds a result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	a_pop_nempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nempty)
		else $error("peak queue popped while empty");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_frac_q <= 9'sd128) && (res_frac_q >= -9'sd128)))
		else $error("fraction out of range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> res_valid_q)
		else $error("loaded result not presented");

endmodule

### src/spectral_peak_frequency_estimator.sv
// Spectral peak frequency estimator.
// Bin channel (bin_valid / bin_stall): power bins of a frame arrive in order
// from bin 0, frame_end marking the last one. Bins are taken one per cycle;
// bin_stall rises only for a frame_end bin while two finished frames are
// still queued for the back end.
// Result channel (res_valid / res_stall): one request per frame carrying
// frequency_hz, peak_index and fraction_q8. The result sits in an output
// register; a stalled result holds, the back end waits behind it, and new
// bins keep being accepted until the queue is full.
// Path from the frame_end bin to res_valid, back end idle: the queue, then the
// back end states IDLE, PREP, CHK, DIV_OFF (a 40-step restoring divider for
// the Q8 offset, only when the peak is refined), POS, MUL, FRQ and DONE into
// the output register. The back end works on one frame at a time, so short
// frames stall the bin channel at their last bin once the queue has filled.
// FFT_POINTS is a power of two; the scale by FFT_POINTS*256 is a shift.
// Configuration (cfg_valid / cfg_ready): index 0 band_low_bin, 1 band_high_bin,
// 2 sample_rate; other indexes are ignored. cfg_ready is always high.
// Reset sets band 9..51 and 4000 Hz, clears the bin position and the queue.
module spectral_peak_frequency_estimator #(
	parameter int FFT_POINTS = spfe_pkg::FFT_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               bin_valid,
	output logic               bin_stall,
	input  logic [31:0]        bin_power,
	input  logic               frame_end,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [15:0]        frequency_hz,
	output logic [7:0]         peak_index,
	output logic signed [8:0]  fraction_q8
);
	import spfe_pkg::*;

	spfe_cfg_t            cfg_q;
	logic                 q_push;
	logic                 q_full;
	logic                 q_pop;
	logic                 q_nempty;
	spfe_peak_t           q_in;
	spfe_peak_t           q_out;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_NUM_W-1:0] div_quo;
	spfe_div_stat_t       div_stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_low    <= BAND_LOW_RST;
			cfg_q.band_high   <= BAND_HIGH_RST;
			cfg_q.sample_rate <= SAMPLE_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BAND_LOW:    cfg_q.band_low    <= cfg_data[7:0];
				CFG_BAND_HIGH:   cfg_q.band_high   <= cfg_data[7:0];
				CFG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_data;
				default: ;
			endcase
		end
	end

	spfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_power (bin_power),
		.frame_end (frame_end),
		.q_push    (q_push),
		.q_data    (q_in),
		.q_full    (q_full)
	);

	spfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.nempty    (q_nempty)
	);

	spfe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	spfe_back #(
		.FFT_POINTS (FFT_POINTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_rate  (cfg_q.sample_rate),
		.q_nempty     (q_nempty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.div_start    (div_start),
		.div_num      (div_num),
		.div_den      (div_den),
		.div_stat     (div_stat),
		.div_quo      (div_quo),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.frequency_hz (frequency_hz),
		.peak_index   (peak_index),
		.fraction_q8  (fraction_q8)
	);

endmodule

### tb/sv/tb_spectral_peak_frequency_estimator.sv
`timescale 1ns / 100ps

module tb_spectral_peak_frequency_estimator;
	import spfe_pkg::*;

	localparam int FFT_N      = FFT_POINTS_DEF;
	localparam int SETTLE     = 120;
	localparam int LONG_HOLD  = 600;
	localparam int ITEM_GOAL  = 1700;
	localparam int FRAME_GOAL = 40;

	typedef struct packed {
		logic [31:0] power;
		logic        last;
	} spectrum_bin_t;

	typedef struct packed {
		logic [15:0]       freq;
		logic [7:0]        peak;
		logic signed [8:0] frac;
	} peak_estimate_t;

	typedef enum logic [1:0] {
		SHAPE_PEAKED,
		SHAPE_SHORT,
		SHAPE_NOISE
	} frame_shape_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               bin_valid = 1'b0;
	logic               bin_stall;
	logic [31:0]        bin_power = '0;
	logic               frame_end = 1'b0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [15:0]        frequency_hz;
	logic [7:0]         peak_index;
	logic signed [8:0]  fraction_q8;

	spectral_peak_frequency_estimator #(
		.FFT_POINTS(FFT_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.bin_valid(bin_valid),
		.bin_stall(bin_stall),
		.bin_power(bin_power),
		.frame_end(frame_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.frequency_hz(frequency_hz),
		.peak_index(peak_index),
		.fraction_q8(fraction_q8)
	);

	always #4 clk = ~clk;

	// pending bins and expected estimates
	spectrum_bin_t  bin_q[$];
	peak_estimate_t estimate_q[$];
	int             items_queued = 0;
	int             frames_queued = 0;
	int             faults = 0;

	// idling control
	logic           calm = 1'b0;
	int             send_odds = 0;
	int             recv_odds = 0;
	int             hold_ask = 0;
	logic           bin_taken = 1'b0;

	// configuration as the block sees it
	logic [7:0]     cur_lo = BAND_LOW_RST;
	logic [7:0]     cur_hi = BAND_HIGH_RST;
	logic [15:0]    cur_rate = SAMPLE_RATE_RST;

	// frame search state
	logic [7:0]     bin_pos = '0;
	logic [31:0]    prev_pw = '0;
	logic [31:0]    peak_pw = '0;
	logic [7:0]     best_idx = '0;
	logic [31:0]    left_pw = '0;
	logic [31:0]    right_pw = '0;
	logic           want_right = 1'b0;
	logic           past_end = 1'b0;

	// track the peak search for one bin; on the frame's last bin work out the estimate
	task automatic estimate_on_bin(input logic [31:0] power, input logic last);
		logic [7:0]        top;
		logic              in_band;
		longint            l, c, r, den, off, pos;
		longint unsigned   hz;
		peak_estimate_t    est;
		top = (cur_hi < cur_lo) ? cur_lo : cur_hi;
		if (!past_end) begin
			// frame start clears the search
			if (bin_pos == 8'd0) begin
				peak_pw = '0;
				best_idx = cur_lo;
				left_pw = '0;
				right_pw = '0;
				want_right = 1'b0;
				prev_pw = '0;
			end
			in_band = (bin_pos >= cur_lo) && (bin_pos <= top);
			if (in_band && (bin_pos == cur_lo || power > peak_pw)) begin
				peak_pw = power;
				best_idx = bin_pos;
				left_pw = prev_pw;
				want_right = 1'b1;
			end else if (want_right) begin
				right_pw = power;
				want_right = 1'b0;
			end
			prev_pw = power;
		end
		if (!last) begin
			// bins past 255 are ignored until the frame ends
			if (bin_pos == 8'd255)
				past_end = 1'b1;
			else if (!past_end)
				bin_pos = bin_pos + 8'd1;
		end else begin
			off = 0;
			// refine only strictly inside the band with the right neighbor seen
			if (best_idx > cur_lo && best_idx < top && !want_right) begin
				l = longint'(left_pw);
				c = longint'(peak_pw);
				r = longint'(right_pw);
				den = l - 2 * c + r;
				if (den != 0)
					off = ((l - r) * 128) / den;
			end
			if (off > 128)
				off = 128;
			if (off < -128)
				off = -128;
			pos = longint'(best_idx) * 256 + off;
			if (pos < 0)
				pos = 0;
			hz = longint'(pos) * longint'(cur_rate) / longint'(FFT_N * 256);
			est.freq = hz[15:0];
			est.peak = best_idx;
			est.frac = off[8:0];
			estimate_q.push_back(est);
			bin_pos = '0;
			past_end = 1'b0;
		end
	endtask

	// bin channel driver: next request goes out at the falling edge
	always @(negedge clk) begin : bin_driver
		int send_gap;
		spectrum_bin_t nxt;
		if (!bin_valid || bin_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				bin_valid <= 1'b0;
			end else if (!calm && send_odds != 0 && $urandom_range(15, 0) < send_odds) begin
				send_gap = $urandom_range(16, 0);
				bin_valid <= 1'b0;
			end else if (bin_q.size() != 0) begin
				nxt = bin_q.pop_front();
				bin_valid <= 1'b1;
				bin_power <= nxt.power;
				frame_end <= nxt.last;
			end else begin
				bin_valid <= 1'b0;
			end
		end
	end

	// result channel stall: random bursts plus a requested long hold-off
	always @(negedge clk) begin : res_staller
		int res_gap;
		int hold_left;
		int hold_seen;
		if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (res_gap > 0) begin
			res_gap--;
			res_stall <= 1'b1;
		end else if (!calm && recv_odds != 0 && $urandom_range(15, 0) < recv_odds) begin
			res_gap = $urandom_range(16, 0);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor: predict on accepted bins, check accepted results
	always @(posedge clk) begin : monitor
		peak_estimate_t est;
		bin_taken <= arst_n && bin_valid && !bin_stall;
		if (arst_n && bin_valid && !bin_stall)
			estimate_on_bin(bin_power, frame_end);
		if (arst_n && res_valid && !res_stall) begin
			if (estimate_q.size() == 0) begin
				$display("%0t: unexpected result: frequency_hz %0d peak_index %0d fraction_q8 %0d",
					$time, frequency_hz, peak_index, fraction_q8);
				faults++;
			end else begin
				est = estimate_q.pop_front();
				if (frequency_hz !== est.freq) begin
					$display("%0t: frequency_hz expected %0d actual %0d",
						$time, est.freq, frequency_hz);
					faults++;
				end
				if (peak_index !== est.peak) begin
					$display("%0t: peak_index expected %0d actual %0d",
						$time, est.peak, peak_index);
					faults++;
				end
				if (fraction_q8 !== est.frac) begin
					$display("%0t: fraction_q8 expected %0d actual %0d",
						$time, est.frac, fraction_q8);
					faults++;
				end
			end
		end
	end

	task automatic push_bin(input logic [31:0] power, input logic last);
		bin_q.push_back('{power: power, last: last});
		items_queued++;
		if (last)
			frames_queued++;
	endtask

	// one configuration request; predictor copy follows on acceptance
	task automatic write_reg(input spfe_cfg_idx_t idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_BAND_LOW:    cur_lo = value[7:0];
			CFG_BAND_HIGH:   cur_hi = value[7:0];
			CFG_SAMPLE_RATE: cur_rate = value;
			default: ;
		endcase
	endtask

	task automatic set_band(input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] rate);
		write_reg(CFG_BAND_LOW, {8'd0, lo});
		write_reg(CFG_BAND_HIGH, {8'd0, hi});
		write_reg(CFG_SAMPLE_RATE, rate);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (bin_q.size() != 0 || bin_valid || estimate_q.size() != 0)
			@(posedge clk);
	endtask

	// random frame for the current band
	task automatic queue_frame(input frame_shape_t shape);
		int          top, len, ctr;
		logic [31:0] amp, flat, pw;
		top = (cur_hi < cur_lo) ? cur_lo : cur_hi;
		amp = ($urandom_range(7, 0) == 0) ? 32'h8000_0000 : $urandom_range(32'h8000_0000, 1);
		flat = $urandom_range(32'h8000_0000, 0);
		ctr = $urandom_range(top, cur_lo);
		case (shape)
			SHAPE_PEAKED: len = top + 2 + $urandom_range(3, 0);
			SHAPE_SHORT:  len = $urandom_range(top + 1, 1);
			default:      len = $urandom_range(top + 4, 1);
		endcase
		for (int i = 0; i < len; i++) begin
			if (shape == SHAPE_NOISE)
				pw = flat[0] ? flat : $urandom_range(32'h8000_0000, 0);
			else if (i == ctr)
				pw = amp;
			else if (i == ctr - 1)
				pw = $urandom_range(amp, 0);
			else if (i == ctr + 1)
				pw = ($urandom_range(5, 0) == 0) ? amp : $urandom_range(amp, 0);
			else
				pw = $urandom_range(amp >> 2, 0);
			push_bin(pw, i == len - 1);
		end
	endtask

	// drain, reprogram, then queue a batch of frames
	task automatic run_phase(input logic [7:0] lo, input logic [7:0] hi, input logic [15:0] rate,
			input int frames, input logic long_hold);
		int pick;
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		set_band(lo, hi, rate);
		calm = (items_queued >= 1500);
		send_odds = long_hold ? 0 : $urandom_range(4, 0);
		recv_odds = $urandom_range(4, 0);
		if (long_hold)
			hold_ask++;
		for (int f = 0; f < frames; f++) begin
			pick = $urandom_range(9, 0);
			queue_frame(pick < 7 ? SHAPE_PEAKED : (pick < 9 ? SHAPE_SHORT : SHAPE_NOISE));
		end
	endtask

	initial begin : stimulus
		logic [7:0]  lo, hi;
		logic [15:0] rate;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames on a narrow band 1..3
		set_band(8'd1, 8'd3, 16'hFFFF);
		send_odds = 2;
		recv_odds = 2;
		// frame ends before the band is reached
		push_bin(32'h8000_0000, 1'b1);
		// right neighbor equals the peak: largest positive offset
		push_bin(32'd0, 1'b0);
		push_bin(32'd0, 1'b0);
		push_bin(32'h8000_0000, 1'b0);
		push_bin(32'h8000_0000, 1'b1);
		// frame ends on the peak before its right neighbor
		push_bin(32'd5, 1'b0);
		push_bin(32'd6, 1'b0);
		push_bin(32'd9, 1'b1);
		// tie keeps the earlier bin, peak on the low edge
		push_bin(32'd7, 1'b0);
		push_bin(32'd50, 1'b0);
		push_bin(32'd50, 1'b0);
		push_bin(32'd10, 1'b0);
		push_bin(32'd3, 1'b1);
		// peak on the high edge
		push_bin(32'd0, 1'b0);
		push_bin(32'd1, 1'b0);
		push_bin(32'd2, 1'b0);
		push_bin(32'd30, 1'b0);
		push_bin(32'd4, 1'b1);
		// left neighbor close to the peak: negative offset
		push_bin(32'd0, 1'b0);
		push_bin(32'd1000, 1'b0);
		push_bin(32'd1001, 1'b0);
		push_bin(32'd0, 1'b1);

		// full-width band with frames that can run past 255 bins, then the inverted extreme
		run_phase(8'd0, 8'd255, 16'hFFFF, 2, 1'b0);
		run_phase(8'd255, 8'd0, 16'd1, 2, 1'b0);
		// reset values again, with a long result hold-off to back up the queue
		run_phase(BAND_LOW_RST, BAND_HIGH_RST, SAMPLE_RATE_RST, 6, 1'b1);

		// random small bands, inverted at times
		while (items_queued < ITEM_GOAL || frames_queued < FRAME_GOAL) begin
			lo = $urandom_range(16, 0);
			hi = $urandom_range(24, 0);
			case ($urandom_range(3, 0))
				0: rate = 16'd1;
				1: rate = 16'hFFFF;
				default: rate = $urandom_range(65535, 1);
			endcase
			run_phase(lo, hi, rate, $urandom_range(8, 3), 1'b0);
		end

		wait_drained();
		repeat (2 * SETTLE) @(posedge clk);
		if (estimate_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, estimate_q.size());
			faults++;
		end
		if (faults == 0)
			$display("tb_spectral_peak_frequency_estimator passed");
		else
			$display("tb_spectral_peak_frequency_estimator failed");
		$finish;
	end

	// overall time limit
	initial begin
		#4_000_000;
		$display("tb_spectral_peak_frequency_estimator failed");
		$finish;
	end

endmodule

### files.f
src/spfe_pkg.sv
src/spfe_front.sv
src/spfe_queue.sv
src/spfe_div.sv
src/spfe_back.sv
src/spectral_peak_frequency_estimator.sv
tb/sv/tb_spectral_peak_frequency_estimator.sv
